>>> rtl/core/variable_record_ring_buffer_assert.svh
// Assertion macros shared by the ring buffer modules.
// Expects clk_i and rst_ni in the scope that uses them; no other dependencies.
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define VRRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define VRRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/vrrb_pkg.sv
// Types and constants of the variable record ring buffer.
// No dependencies; the files that use it refer to it by scoped names.
package vrrb_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_SEQ      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_PUT_HDR  = 2'd0,
    MODE_PUT_DATA = 2'd1,
    MODE_GET_HDR  = 2'd2,
    MODE_GET_DATA = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_READ_HDR,
    JOB_READ_DATA
  } job_kind_e;

  // Work handed from the front end to the back end
  typedef struct packed {
    job_kind_e   kind;
    status_e     status;
    logic        last;
    logic [7:0]  len;    // reader capacity for a header read
    logic [31:0] wdata;
  } job_t;

  // Outcome of a header read, returned to the front end
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] len;
  } hdr_fb_t;

  localparam int unsigned WordW = 32;

  function automatic logic [31:0] pack_hdr(logic [15:0] rtype, logic [7:0] rlen,
                                           logic [7:0] rvalue);
    return {rvalue, rlen, rtype};
  endfunction

endpackage

>>> rtl/core/variable_record_ring_buffer.sv
// Ring buffer of variable-length records. A taken request is held in the queue, then its
// store access is registered, and the result follows. One request per cycle; a get header
// holds busy until its header word has been read back from the store, since that length sets
// the get state. The result strobe lasts one cycle and cannot be stalled. Reset clears the
// indices and counters at once; the word store needs no clearing.
// Depends on vrrb_pkg, vrrb_front, vrrb_queue, vrrb_back, vrrb_ram.
module variable_record_ring_buffer #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] rec_type_i,
  input  logic [7:0]  rec_value_i,
  input  logic [7:0]  rec_length_i,
  input  logic [31:0] data_word_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [15:0] out_type_o,
  output logic [7:0]  out_value_o,
  output logic [7:0]  out_length_o,
  output logic [31:0] out_word_o,
  output logic        last_word_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = AW + $bits(vrrb_pkg::job_t);

  logic              accept, push, wait_hdr, q_full, q_valid, pop;
  vrrb_pkg::job_t    f_job, q_job;
  logic [AW-1:0]     f_addr, q_addr;
  logic [QW-1:0]     q_out;
  vrrb_pkg::hdr_fb_t fb;

  // Take a request when idle
  assign busy   = wait_hdr || q_full;
  assign accept = start && !busy;

  vrrb_front #(.AW(AW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .rec_type_i  (rec_type_i),
    .rec_value_i (rec_value_i),
    .rec_length_i(rec_length_i),
    .data_word_i (data_word_i),
    .fb_i        (fb),
    .push_o      (push),
    .job_o       (f_job),
    .addr_o      (f_addr),
    .wait_o      (wait_hdr)
  );

  vrrb_queue #(.W(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_addr, f_job}),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .data_o (q_out)
  );

  assign q_addr = q_out[QW-1 -: AW];
  assign q_job  = q_out[$bits(vrrb_pkg::job_t)-1:0];

  vrrb_back #(.AW(AW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .q_addr_i    (q_addr),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .out_type_o  (out_type_o),
    .out_value_o (out_value_o),
    .out_length_o(out_length_o),
    .out_word_o  (out_word_o),
    .last_word_o (last_word_o),
    .fb_o        (fb)
  );

endmodule

>>> rtl/core/vrrb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module vrrb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/vrrb_front.sv
// Front end: accepts requests, checks sequence and space, owns the ring indices.
// Depends on vrrb_pkg and the assertion macro header.
`include "variable_record_ring_buffer_assert.svh"

module vrrb_front #(
  parameter int unsigned AW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       mode_i,
  input  logic [15:0]      rec_type_i,
  input  logic [7:0]       rec_value_i,
  input  logic [7:0]       rec_length_i,
  input  logic [31:0]      data_word_i,
  input  vrrb_pkg::hdr_fb_t fb_i,
  output logic             push_o,
  output vrrb_pkg::job_t   job_o,
  output logic [AW-1:0]    addr_o,
  output logic             wait_o
);

  logic [AW-1:0] read_q, read_d, write_q, write_d;
  logic [AW-1:0] put_cur_q, put_cur_d, get_cur_q, get_cur_d;
  logic [7:0]    put_left_q, put_left_d, get_left_q, get_left_d;
  logic          wait_q, wait_d;
  logic [AW-1:0] free_words;
  logic [16:0]   free_ext, need_ext;
  vrrb_pkg::job_t job;
  logic [AW-1:0] addr;

  // Free space is one word short of the unused part of the ring
  assign free_words = read_q - write_q - AW'(1);
  assign free_ext   = 17'(free_words);
  assign need_ext   = 17'(rec_length_i) + 17'd1;

  // Classify the request and advance the indices
  always_comb begin
    read_d     = read_q;
    write_d    = write_q;
    put_cur_d  = put_cur_q;
    get_cur_d  = get_cur_q;
    put_left_d = put_left_q;
    get_left_d = get_left_q;
    wait_d     = wait_q;
    job        = '{kind: vrrb_pkg::JOB_NONE, status: vrrb_pkg::ST_OK, last: 1'b0,
                   len: 8'd0, wdata: 32'd0};
    addr       = '0;

    // Open or refuse the get once its header has been read
    if (fb_i.valid) begin
      wait_d = 1'b0;
      if (fb_i.ok) begin
        get_cur_d  = read_q + AW'(1);
        get_left_d = fb_i.len;
        if (fb_i.len == 8'd0) begin
          read_d = read_q + AW'(1);
        end
      end
    end

    if (accept_i) begin
      case (vrrb_pkg::mode_e'(mode_i))
        vrrb_pkg::MODE_PUT_HDR: begin
          if (put_left_q != 8'd0) begin
            job.status = vrrb_pkg::ST_SEQ;
          end else if (free_ext < need_ext) begin
            job.status = vrrb_pkg::ST_NO_SPACE;
          end else begin
            job.kind   = vrrb_pkg::JOB_WRITE;
            job.wdata  = vrrb_pkg::pack_hdr(rec_type_i, rec_length_i, rec_value_i);
            addr       = write_q;
            put_cur_d  = write_q + AW'(1);
            put_left_d = rec_length_i;
            if (rec_length_i == 8'd0) begin
              write_d  = write_q + AW'(1);
              job.last = 1'b1;
            end
          end
        end
        vrrb_pkg::MODE_PUT_DATA: begin
          if (put_left_q == 8'd0) begin
            job.status = vrrb_pkg::ST_SEQ;
          end else begin
            job.kind   = vrrb_pkg::JOB_WRITE;
            job.wdata  = data_word_i;
            addr       = put_cur_q;
            put_cur_d  = put_cur_q + AW'(1);
            put_left_d = put_left_q - 8'd1;
            if (put_left_q == 8'd1) begin
              write_d  = put_cur_q + AW'(1);
              job.last = 1'b1;
            end
          end
        end
        vrrb_pkg::MODE_GET_HDR: begin
          if (get_left_q != 8'd0) begin
            job.status = vrrb_pkg::ST_SEQ;
          end else if (read_q == write_q) begin
            job.status = vrrb_pkg::ST_EMPTY;
          end else begin
            job.kind = vrrb_pkg::JOB_READ_HDR;
            job.len  = rec_length_i;
            addr     = read_q;
            wait_d   = 1'b1;
          end
        end
        vrrb_pkg::MODE_GET_DATA: begin
          if (get_left_q == 8'd0) begin
            job.status = vrrb_pkg::ST_SEQ;
          end else begin
            job.kind   = vrrb_pkg::JOB_READ_DATA;
            addr       = get_cur_q;
            get_cur_d  = get_cur_q + AW'(1);
            get_left_d = get_left_q - 8'd1;
            if (get_left_q == 8'd1) begin
              read_d   = get_cur_q + AW'(1);
              job.last = 1'b1;
            end
          end
        end
        default: begin
          job.status = vrrb_pkg::ST_SEQ;
        end
      endcase
    end
  end

  // Hold the ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q     <= '0;
      write_q    <= '0;
      put_cur_q  <= '0;
      get_cur_q  <= '0;
      put_left_q <= '0;
      get_left_q <= '0;
      wait_q     <= 1'b0;
    end else begin
      read_q     <= read_d;
      write_q    <= write_d;
      put_cur_q  <= put_cur_d;
      get_cur_q  <= get_cur_d;
      put_left_q <= put_left_d;
      get_left_q <= get_left_d;
      wait_q     <= wait_d;
    end
  end

  assign push_o = accept_i;
  assign job_o  = job;
  assign addr_o = addr;
  assign wait_o = wait_q;

  `VRRB_ASSERT_NOW(a_fb_only_when_waiting, fb_i.valid, wait_q, "header result without pending get")
  `VRRB_ASSERT_NOW(a_no_accept_while_waiting, accept_i, !wait_q, "request taken during header read")
  `VRRB_ASSERT_NEXT(a_wait_from_hdr_read, !wait_q && push_o && job.kind == vrrb_pkg::JOB_READ_HDR,
                    wait_q, "header read did not block the front end")

endmodule

>>> rtl/core/vrrb_queue.sv
// Two-entry queue between front and back ends.
// Depends on the assertion macro header.
`include "variable_record_ring_buffer_assert.svh"

module vrrb_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   count_q;

  // Store incoming requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = slot_q[rptr_q];

  `VRRB_ASSERT_NOW(a_no_overflow, push_i, !full_o || pop_i, "push into full queue")
  `VRRB_ASSERT_NOW(a_no_underflow, pop_i, valid_o, "pop from empty queue")

endmodule

>>> rtl/core/vrrb_back.sv
// Back end: executes word accesses on the store and drives the result.
// Depends on vrrb_pkg and vrrb_ram.
module vrrb_back #(
  parameter int unsigned AW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  vrrb_pkg::job_t    q_job_i,
  input  logic [AW-1:0]     q_addr_i,
  output logic              pop_o,
  output logic              strobe_o,
  output logic [2:0]        status_o,
  output logic [15:0]       out_type_o,
  output logic [7:0]        out_value_o,
  output logic [7:0]        out_length_o,
  output logic [31:0]       out_word_o,
  output logic              last_word_o,
  output vrrb_pkg::hdr_fb_t fb_o
);

  logic           s1_valid_q;
  vrrb_pkg::job_t s1_job_q;
  logic [31:0]    rdata;
  logic           ram_we, ram_re;
  logic [7:0]     hdr_len;
  logic           hdr_ok, is_hdr;

  // Drain one job per cycle
  assign pop_o  = q_valid_i;
  assign ram_we = pop_o && (q_job_i.kind == vrrb_pkg::JOB_WRITE);
  assign ram_re = pop_o && ((q_job_i.kind == vrrb_pkg::JOB_READ_HDR) ||
                            (q_job_i.kind == vrrb_pkg::JOB_READ_DATA));

  vrrb_ram #(
    .Width(vrrb_pkg::WordW),
    .Depth(1 << AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (q_addr_i),
    .wdata_i(q_job_i.wdata),
    .rdata_o(rdata)
  );

  // Track the job whose access is under way
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_job_q <= q_job_i;
    end
  end

  // Check the stored length against the reader capacity
  assign is_hdr  = (s1_job_q.kind == vrrb_pkg::JOB_READ_HDR);
  assign hdr_len = rdata[23:16];
  assign hdr_ok  = (hdr_len <= s1_job_q.len);

  // Form the result
  always_comb begin
    status_o     = s1_job_q.status;
    out_type_o   = 16'd0;
    out_value_o  = 8'd0;
    out_length_o = 8'd0;
    out_word_o   = 32'd0;
    last_word_o  = s1_job_q.last;
    case (s1_job_q.kind)
      vrrb_pkg::JOB_READ_HDR: begin
        out_length_o = hdr_len;
        last_word_o  = hdr_ok && (hdr_len == 8'd0);
        if (hdr_ok) begin
          status_o    = vrrb_pkg::ST_OK;
          out_type_o  = rdata[15:0];
          out_value_o = rdata[31:24];
        end else begin
          status_o = vrrb_pkg::ST_TOO_BIG;
        end
      end
      vrrb_pkg::JOB_READ_DATA: begin
        out_word_o = rdata;
      end
      default: begin
      end
    endcase
  end

  assign strobe_o  = s1_valid_q;
  assign fb_o.valid = s1_valid_q && is_hdr;
  assign fb_o.ok    = hdr_ok;
  assign fb_o.len   = hdr_len;

endmodule

>>> tb/sv/variable_record_ring_buffer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the variable record ring buffer: directed and random tests.
// Holds its own image of the ring to predict every reply. Depends on vrrb_pkg and the RTL.
module variable_record_ring_buffer_tb;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    vrrb_pkg::status_e status;
    logic [15:0]       rtype;
    logic [7:0]        rvalue;
    logic [7:0]        length;
    logic [31:0]       word;
    logic              last;
  } ring_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_mode = 2'd0;
  logic [15:0] req_type = 16'd0;
  logic [7:0]  req_value = 8'd0;
  logic [7:0]  req_length = 8'd0;
  logic [31:0] req_word = 32'd0;
  logic        strobe_o;
  logic [2:0]  status_o;
  logic [15:0] out_type_o;
  logic [7:0]  out_value_o;
  logic [7:0]  out_length_o;
  logic [31:0] out_word_o;
  logic        last_word_o;

  // Image of the ring as the block should hold it
  logic [31:0]   ring_image [DEPTH];
  logic [IW-1:0] rd_idx = '0;
  logic [IW-1:0] wr_idx = '0;
  logic [IW-1:0] put_cur = '0;
  logic [IW-1:0] get_cur = '0;
  logic [7:0]    put_left = '0;
  logic [7:0]    get_left = '0;

  ring_reply_t awaited_replies [$];
  int          sender_idle_pct = 0;
  int          requests_sent = 0;
  int          replies_checked = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          status_seen [5] = '{default: 0};

  variable_record_ring_buffer #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (req_mode),
    .rec_type_i  (req_type),
    .rec_value_i (req_value),
    .rec_length_i(req_length),
    .data_word_i (req_word),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .out_type_o  (out_type_o),
    .out_value_o (out_value_o),
    .out_length_o(out_length_o),
    .out_word_o  (out_word_o),
    .last_word_o (last_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Words held by committed records
  function automatic int ring_used();
    logic [IW-1:0] used;
    used = wr_idx - rd_idx;
    return int'(used);
  endfunction

  // Apply one request to the ring image and return the reply it must produce
  function automatic ring_reply_t advance_ring_image(input vrrb_pkg::mode_e m,
                                                     input logic [15:0] rtype,
                                                     input logic [7:0] rvalue,
                                                     input logic [7:0] rlen,
                                                     input logic [31:0] dword);
    ring_reply_t   r;
    logic [31:0]   hdr;
    logic [IW-1:0] free;
    r = '0;
    r.status = vrrb_pkg::ST_OK;
    free = rd_idx - wr_idx - IW'(1);
    case (m)
      vrrb_pkg::MODE_PUT_HDR: begin
        if (put_left != 0) begin
          r.status = vrrb_pkg::ST_SEQ;
        end else if (int'(free) < int'(rlen) + 1) begin
          r.status = vrrb_pkg::ST_NO_SPACE;
        end else begin
          ring_image[wr_idx] = {rvalue, rlen, rtype};
          put_cur = wr_idx + IW'(1);
          put_left = rlen;
          // commit an empty record at once
          if (rlen == 0) begin
            wr_idx = put_cur;
            r.last = 1'b1;
          end
        end
      end
      vrrb_pkg::MODE_PUT_DATA: begin
        if (put_left == 0) begin
          r.status = vrrb_pkg::ST_SEQ;
        end else begin
          ring_image[put_cur] = dword;
          put_cur = put_cur + IW'(1);
          put_left = put_left - 8'd1;
          if (put_left == 0) begin
            wr_idx = put_cur;
            r.last = 1'b1;
          end
        end
      end
      vrrb_pkg::MODE_GET_HDR: begin
        if (get_left != 0) begin
          r.status = vrrb_pkg::ST_SEQ;
        end else if (rd_idx == wr_idx) begin
          r.status = vrrb_pkg::ST_EMPTY;
        end else begin
          hdr = ring_image[rd_idx];
          r.length = hdr[23:16];
          if (hdr[23:16] > rlen) begin
            r.status = vrrb_pkg::ST_TOO_BIG;
          end else begin
            r.rtype = hdr[15:0];
            r.rvalue = hdr[31:24];
            get_cur = rd_idx + IW'(1);
            get_left = hdr[23:16];
            // free an empty record at once
            if (hdr[23:16] == 0) begin
              rd_idx = get_cur;
              r.last = 1'b1;
            end
          end
        end
      end
      default: begin
        if (get_left == 0) begin
          r.status = vrrb_pkg::ST_SEQ;
        end else begin
          r.word = ring_image[get_cur];
          get_cur = get_cur + IW'(1);
          get_left = get_left - 8'd1;
          if (get_left == 0) begin
            rd_idx = get_cur;
            r.last = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
  endtask

  // Drive one request, sometimes after a random idle gap, and hold it until taken
  task automatic send_request(input vrrb_pkg::mode_e m, input logic [15:0] rtype,
                              input logic [7:0] rvalue, input logic [7:0] rlen,
                              input logic [31:0] dword);
    int gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_mode <= m;
    req_type <= rtype;
    req_value <= rvalue;
    req_length <= rlen;
    req_word <= dword;
    do @(posedge clk_i); while (busy);
    awaited_replies.push_back(advance_ring_image(m, rtype, rvalue, rlen, dword));
    requests_sent++;
  endtask

  // Hold off new requests until every awaited reply is in
  task automatic wait_for_replies();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
  endtask

  // Empty reads, sequence errors, field extremes and a too-big reader
  task automatic test_directed_cases();
    send_request(vrrb_pkg::MODE_GET_HDR, 16'h0000, 8'h00, 8'hFF, 32'h0);
    send_request(vrrb_pkg::MODE_GET_DATA, 16'h0000, 8'h00, 8'h00, 32'h0);
    send_request(vrrb_pkg::MODE_PUT_DATA, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(vrrb_pkg::MODE_PUT_HDR, 16'hFFFF, 8'hFF, 8'h00, 32'h0);
    send_request(vrrb_pkg::MODE_PUT_HDR, 16'h0000, 8'h00, 8'h02, 32'hFFFF_FFFF);
    send_request(vrrb_pkg::MODE_PUT_HDR, 16'h1234, 8'h5A, 8'h01, 32'h0);
    send_request(vrrb_pkg::MODE_PUT_DATA, 16'h0000, 8'h00, 8'h00, 32'hFFFF_FFFF);
    send_request(vrrb_pkg::MODE_PUT_DATA, 16'hFFFF, 8'hFF, 8'hFF, 32'h0000_0000);
    send_request(vrrb_pkg::MODE_PUT_DATA, 16'h0000, 8'h00, 8'h00, 32'hA5A5_5A5A);
    send_request(vrrb_pkg::MODE_GET_HDR, 16'h0000, 8'h00, 8'h00, 32'h0);
    send_request(vrrb_pkg::MODE_GET_HDR, 16'hFFFF, 8'hFF, 8'h01, 32'hFFFF_FFFF);
    send_request(vrrb_pkg::MODE_GET_HDR, 16'h0000, 8'h00, 8'h02, 32'h0);
    send_request(vrrb_pkg::MODE_GET_HDR, 16'h0000, 8'h00, 8'hFF, 32'h0);
    send_request(vrrb_pkg::MODE_GET_DATA, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(vrrb_pkg::MODE_GET_DATA, 16'h0000, 8'h00, 8'h00, 32'h0);
    send_request(vrrb_pkg::MODE_GET_DATA, 16'h0000, 8'h00, 8'h00, 32'h0);
    send_request(vrrb_pkg::MODE_GET_HDR, 16'h0000, 8'h00, 8'hFF, 32'h0);
  endtask

  // Mostly well-formed puts and gets with random content, some noise
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    int              pick;
    int              roll;
    logic [7:0]      len;
    logic [7:0]      head_len;
    vrrb_pkg::mode_e m;
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      roll = $urandom_range(0, 99);
      len = 8'($urandom);
      if (pick < 8) begin
        m = vrrb_pkg::mode_e'(2'($urandom_range(0, 3)));
      end else if (put_left != 0 && pick < 60) begin
        m = vrrb_pkg::MODE_PUT_DATA;
      end else if (get_left != 0 && pick < 85) begin
        m = vrrb_pkg::MODE_GET_DATA;
      end else if (ring_used() > 700 || $urandom_range(0, 1) == 1) begin
        m = vrrb_pkg::MODE_GET_HDR;
        head_len = (rd_idx != wr_idx) ? ring_image[rd_idx][23:16] : 8'd0;
        if (roll < 12 && head_len != 0) begin
          len = head_len - 8'd1;
        end else if (roll < 80) begin
          len = 8'hFF;
        end
      end else begin
        m = vrrb_pkg::MODE_PUT_HDR;
        if (roll < 70) begin
          len = 8'($urandom_range(0, 7));
        end else if (roll < 93) begin
          len = 8'($urandom_range(8, 40));
        end else begin
          len = 8'($urandom_range(41, 255));
        end
      end
      send_request(m, 16'($urandom), 8'($urandom), len, $urandom);
    end
  endtask

  // Compare each reply with the oldest prediction
  always @(posedge clk_i) begin
    ring_reply_t want;
    if (rst_ni && strobe_o) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with none awaited, status", 32'(status_o), 32'hX);
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        status_seen[want.status]++;
        if (status_o !== want.status) report_mismatch("status", 32'(status_o), 32'(want.status));
        if (out_type_o !== want.rtype) report_mismatch("out_type", 32'(out_type_o), 32'(want.rtype));
        if (out_value_o !== want.rvalue) begin
          report_mismatch("out_value", 32'(out_value_o), 32'(want.rvalue));
        end
        if (out_length_o !== want.length) begin
          report_mismatch("out_length", 32'(out_length_o), 32'(want.length));
        end
        if (out_word_o !== want.word) report_mismatch("out_word", out_word_o, want.word);
        if (last_word_o !== want.last) begin
          report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
        end
      end
    end
  end

  // Count cycles in which neither a request nor a reply moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 23;
    test_directed_cases();
    test_random_traffic(23, 178);
    wait_for_replies();
    test_random_traffic(75, 178);
    wait_for_replies();
    test_random_traffic(0, 178);
    wait_for_replies();
    repeat (8) @(negedge clk_i);

    if (awaited_replies.size() != 0) begin
      report_mismatch("replies never delivered", 32'(awaited_replies.size()), 32'd0);
    end
    $display("Checked %0d of %0d requests: directed edges, sequence errors, too-big readers,",
             replies_checked, requests_sent);
    $display("random puts and gets. Replies: ok %0d, no space %0d, empty %0d, too big %0d, seq %0d",
             status_seen[vrrb_pkg::ST_OK], status_seen[vrrb_pkg::ST_NO_SPACE],
             status_seen[vrrb_pkg::ST_EMPTY], status_seen[vrrb_pkg::ST_TOO_BIG],
             status_seen[vrrb_pkg::ST_SEQ]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
